/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module of the convolution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is high.
`define C2D_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("conv2d check failed");

// Implication checked in the cycle after the antecedent, disabled while reset is high.
`define C2D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("conv2d check failed");

`endif

/* rtl/core/c2d_pkg.sv */
// Shared constants, payload types and codes of the convolution layer block.
package c2d_pkg;

   // Store geometry.
   localparam int MAX_WIDTH    = 64;
   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_CHANNELS = 16;
   localparam int MAX_FILTERS  = 32;
   localparam int MAX_KERNEL   = 7;
   localparam int MAX_STRIDE   = 7;

   localparam int SAMPLE_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int WEIGHT_DEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
   localparam int BIAS_DEPTH   = MAX_FILTERS;

   localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH);
   localparam int WEIGHT_AW = $clog2(WEIGHT_DEPTH);
   localparam int BIAS_AW   = $clog2(BIAS_DEPTH);
   localparam int CH_W      = $clog2(MAX_CHANNELS);

   // Accumulator holds up to 784 full-scale products plus the scaled bias.
   localparam int ACC_W = 42;

   // Request kinds.
   localparam logic [1:0] KIND_SAMPLE  = 2'd0;
   localparam logic [1:0] KIND_WEIGHT  = 2'd1;
   localparam logic [1:0] KIND_BIAS    = 2'd2;
   localparam logic [1:0] KIND_COMPUTE = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_CHANNELS = 3'd2;
   localparam logic [2:0] CSR_FILTERS  = 3'd3;
   localparam logic [2:0] CSR_KERNEL   = 3'd4;
   localparam logic [2:0] CSR_STRIDE   = 3'd5;

   // Result status codes.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_OUTSIDE = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        index;
      logic signed [15:0] value;
      logic [4:0]         out_filter;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               status;
   } rsp_type;

   // Write into one of the stores.
   typedef struct packed {
      logic               en;
      logic [1:0]         kind;
      logic [15:0]        index;
      logic signed [15:0] value;
   } load_type;

   // One multiply-accumulate read issued by the address sequencer.
   typedef struct packed {
      logic                 active;
      logic [SAMPLE_AW-1:0] s_addr;
      logic [WEIGHT_AW-1:0] w_addr;
   } issue_type;

endpackage

/* rtl/core/conv2d_layer_forward_unit.sv */
// Top level of the convolution layer forward unit: registers, setup and sequencing.
//
// Channel  Dir  Payload          Handshake
// req      in   req_type         req_valid / req_ready
// rsp      out  rsp_type         rsp_valid / rsp_ready
// csr      in   csr_index, data  csr_valid / csr_ready (always ready)
//
// A sample, weight or bias load is written in the cycle of its transfer; req_ready stays high.
// A compute request runs three setup states, then walks the taps one per cycle through the
// single multiply-accumulate unit, drains the read and product registers and posts the result.
// A request outside the output grid skips the tap walk and goes from setup straight to posting.
// Synchronous reset restores the register defaults; the stores are not cleared.
// A result waiting on rsp_ready holds; loads are still taken, a compute request waits to post.
module conv2d_layer_forward_unit import c2d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP1 = 3'd1;
   localparam logic [2:0] ST_SETUP2 = 3'd2;
   localparam logic [2:0] ST_SETUP3 = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   // Configuration registers as written.
   logic [6:0] width_ff;
   logic [6:0] height_ff;
   logic [4:0] chans_ff;
   logic [5:0] filters_ff;
   logic [2:0] kernel_ff;
   logic [2:0] stride_ff;

   // Effective values after range limiting.
   logic [6:0] w_eff;
   logic [6:0] h_eff;
   logic [4:0] c_eff;
   logic [5:0] nf_eff;
   logic [2:0] k_eff;
   logic [2:0] s_eff;

   logic [2:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rd_vld_ff;

   logic [4:0]  f_ff, f_in;
   logic [5:0]  orow_ff, orow_in;
   logic [5:0]  ocol_ff, ocol_in;
   logic [8:0]  rs_ff, rs_in;
   logic [8:0]  cs_ff, cs_in;
   logic [5:0]  kk_ff, kk_in;
   logic [12:0] hw_ff, hw_in;
   logic        ok_ff, ok_in;
   logic [15:0] rowbase_ff, rowbase_in;
   logic [9:0]  kkc_ff, kkc_in;

   logic                 req_fire;
   logic                 agu_start;
   logic                 mac_clear;
   logic [SAMPLE_AW-1:0] sbase;
   logic [WEIGHT_AW-1:0] wbase;
   load_type             load;
   issue_type            issue;
   logic signed [15:0]   sample_q;
   logic signed [15:0]   weight_q;
   logic signed [15:0]   bias_q;
   logic                 mac_busy;
   logic signed [31:0]   sat_result;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 7'd1;
         height_ff  <= 7'd1;
         chans_ff   <= 5'd1;
         filters_ff <= 6'd1;
         kernel_ff  <= 3'd3;
         stride_ff  <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:    width_ff   <= csr_data;
            CSR_HEIGHT:   height_ff  <= csr_data;
            CSR_CHANNELS: chans_ff   <= csr_data[4:0];
            CSR_FILTERS:  filters_ff <= csr_data[5:0];
            CSR_KERNEL:   kernel_ff  <= csr_data[2:0];
            CSR_STRIDE:   stride_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one, anything above the maximum acts as the maximum.
   always_comb begin
      w_eff  = (width_ff == '0) ? 7'd1 :
               (width_ff > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_ff;
      h_eff  = (height_ff == '0) ? 7'd1 :
               (height_ff > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_ff;
      c_eff  = (chans_ff == '0) ? 5'd1 :
               (chans_ff > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : chans_ff;
      nf_eff = (filters_ff == '0) ? 6'd1 :
               (filters_ff > 6'(MAX_FILTERS)) ? 6'(MAX_FILTERS) : filters_ff;
      k_eff  = (kernel_ff == '0) ? 3'd1 :
               (kernel_ff > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_ff;
      s_eff  = (stride_ff == '0) ? 3'd1 :
               (stride_ff > 3'(MAX_STRIDE)) ? 3'(MAX_STRIDE) : stride_ff;
   end

   // Loads go straight to the stores.
   assign load.en    = req_fire && (req_data.kind != KIND_COMPUTE);
   assign load.kind  = req_data.kind;
   assign load.index = req_data.index;
   assign load.value = req_data.value;

   // Window origin in the sample store and filter origin in the weight store.
   assign sbase = SAMPLE_AW'(rowbase_ff + 16'(cs_ff));
   assign wbase = WEIGHT_AW'(15'(f_ff) * 15'(kkc_ff));

   // Sequencer: setup products, grid check, tap walk, drain, post.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      f_in         = f_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      rs_in        = rs_ff;
      cs_in        = cs_ff;
      kk_in        = kk_ff;
      hw_in        = hw_ff;
      ok_in        = ok_ff;
      rowbase_in   = rowbase_ff;
      kkc_in       = kkc_ff;
      agu_start    = 1'b0;
      mac_clear    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.kind == KIND_COMPUTE)) begin
               f_in     = req_data.out_filter;
               orow_in  = req_data.out_row;
               ocol_in  = req_data.out_col;
               state_in = ST_SETUP1;
            end
         end
         ST_SETUP1: begin
            rs_in    = 9'(orow_ff) * 9'(s_eff);
            cs_in    = 9'(ocol_ff) * 9'(s_eff);
            kk_in    = 6'(k_eff) * 6'(k_eff);
            hw_in    = 13'(h_eff) * 13'(w_eff);
            state_in = ST_SETUP2;
         end
         ST_SETUP2: begin
            // Inside the grid when the filter exists and the window's far edge stays within the image.
            ok_in      = (6'(f_ff) < nf_eff) &&
                         ((10'(rs_ff) + 10'(k_eff)) <= 10'(h_eff)) &&
                         ((10'(cs_ff) + 10'(k_eff)) <= 10'(w_eff));
            rowbase_in = 16'(rs_ff) * 16'(w_eff);
            kkc_in     = 10'(kk_ff) * 10'(c_eff);
            state_in   = ST_SETUP3;
         end
         ST_SETUP3: begin
            if (ok_ff) begin
               agu_start = 1'b1;
               mac_clear = 1'b1;
               state_in  = ST_RUN;
            end else begin
               state_in  = ST_FINISH;
            end
         end
         ST_RUN: begin
            if (!issue.active && !rd_vld_ff && !mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (ok_ff) begin
                  rsp_in.result = sat_result;
                  rsp_in.status = STATUS_OK;
               end else begin
                  rsp_in.result = '0;
                  rsp_in.status = STATUS_OUTSIDE;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= issue.active;
      end
   end

   // Request fields, setup products and result register.
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      f_ff       <= f_in;
      orow_ff    <= orow_in;
      ocol_ff    <= ocol_in;
      rs_ff      <= rs_in;
      cs_ff      <= cs_in;
      kk_ff      <= kk_in;
      hw_ff      <= hw_in;
      ok_ff      <= ok_in;
      rowbase_ff <= rowbase_in;
      kkc_ff     <= kkc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   c2d_store u_store (
      .clock     (clock),
      .load      (load),
      .issue     (issue),
      .bias_addr (f_ff),
      .sample_q  (sample_q),
      .weight_q  (weight_q),
      .bias_q    (bias_q)
   );

   c2d_agu u_agu (
      .clock (clock),
      .reset (reset),
      .start (agu_start),
      .sbase (sbase),
      .wbase (wbase),
      .k     (k_eff),
      .c     (c_eff),
      .w     (w_eff),
      .hw    (hw_ff),
      .issue (issue)
   );

   c2d_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .clear      (mac_clear),
      .bias       (bias_q),
      .in_vld     (rd_vld_ff),
      .sample     (sample_q),
      .weight     (weight_q),
      .busy       (mac_busy),
      .sat_result (sat_result)
   );

endmodule

/* rtl/core/c2d_store.sv */
// Sample, weight and bias memories with one write and one registered read each.
module c2d_store import c2d_pkg::*; (
   input  logic                  clock,
   input  load_type              load,
   input  issue_type             issue,
   input  logic [BIAS_AW-1:0]    bias_addr,
   output logic signed [15:0]    sample_q,
   output logic signed [15:0]    weight_q,
   output logic signed [15:0]    bias_q
);

   logic signed [15:0] sample_mem [SAMPLE_DEPTH];
   logic signed [15:0] weight_mem [WEIGHT_DEPTH];
   logic signed [15:0] bias_mem   [BIAS_DEPTH];

   logic signed [15:0] sample_q_ff;
   logic signed [15:0] weight_q_ff;
   logic signed [15:0] bias_q_ff;

   logic sample_we;
   logic weight_we;
   logic bias_we;

   // A load beyond its store is dropped.
   assign sample_we = load.en && (load.kind == KIND_SAMPLE) && (32'(load.index) < SAMPLE_DEPTH);
   assign weight_we = load.en && (load.kind == KIND_WEIGHT) && (32'(load.index) < WEIGHT_DEPTH);
   assign bias_we   = load.en && (load.kind == KIND_BIAS) && (32'(load.index) < BIAS_DEPTH);

   // Sample memory.
   always_ff @(posedge clock) begin
      if (sample_we) begin
         sample_mem[load.index[SAMPLE_AW-1:0]] <= load.value;
      end
      sample_q_ff <= sample_mem[issue.s_addr];
   end

   // Weight memory.
   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[load.index[WEIGHT_AW-1:0]] <= load.value;
      end
      weight_q_ff <= weight_mem[issue.w_addr];
   end

   // Bias memory.
   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[load.index[BIAS_AW-1:0]] <= load.value;
      end
      bias_q_ff <= bias_mem[bias_addr];
   end

   assign sample_q = sample_q_ff;
   assign weight_q = weight_q_ff;
   assign bias_q   = bias_q_ff;

endmodule

/* rtl/core/c2d_agu.sv */
// Address sequencer that walks channel, kernel row and kernel column of one window.
module c2d_agu import c2d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SAMPLE_AW-1:0] sbase,
   input  logic [WEIGHT_AW-1:0] wbase,
   input  logic [2:0]           k,
   input  logic [4:0]           c,
   input  logic [6:0]           w,
   input  logic [12:0]          hw,
   output issue_type            issue
);

   logic                 active_ff, active_in;
   logic [2:0]           kc_ff, kc_in;
   logic [2:0]           kr_ff, kr_in;
   logic [CH_W-1:0]      ch_ff, ch_in;
   logic [SAMPLE_AW-1:0] s_addr_ff, s_addr_in;
   logic [SAMPLE_AW-1:0] row_ff, row_in;
   logic [SAMPLE_AW-1:0] chan_ff, chan_in;
   logic [WEIGHT_AW-1:0] w_addr_ff, w_addr_in;

   logic                 kc_last;
   logic                 kr_last;
   logic                 ch_last;
   logic [SAMPLE_AW-1:0] chan_next;
   logic [SAMPLE_AW-1:0] row_next;

   assign kc_last   = (kc_ff == (k - 3'd1));
   assign kr_last   = (kr_ff == (k - 3'd1));
   assign ch_last   = (5'(ch_ff) == (c - 5'd1));
   assign chan_next = chan_ff + SAMPLE_AW'(hw);
   assign row_next  = row_ff + SAMPLE_AW'(w);

   // Next tap: step the column, wrap into the next image row, then the next channel.
   // The weight address is simply sequential over the whole filter.
   always_comb begin
      active_in = active_ff;
      kc_in     = kc_ff;
      kr_in     = kr_ff;
      ch_in     = ch_ff;
      s_addr_in = s_addr_ff;
      row_in    = row_ff;
      chan_in   = chan_ff;
      w_addr_in = w_addr_ff;
      if (start) begin
         active_in = 1'b1;
         kc_in     = '0;
         kr_in     = '0;
         ch_in     = '0;
         s_addr_in = sbase;
         row_in    = sbase;
         chan_in   = sbase;
         w_addr_in = wbase;
      end else if (active_ff) begin
         w_addr_in = w_addr_ff + WEIGHT_AW'(1);
         if (kc_last) begin
            kc_in = '0;
            if (kr_last) begin
               kr_in     = '0;
               ch_in     = ch_ff + CH_W'(1);
               chan_in   = chan_next;
               row_in    = chan_next;
               s_addr_in = chan_next;
               if (ch_last) begin
                  active_in = 1'b0;
               end
            end else begin
               kr_in     = kr_ff + 3'd1;
               row_in    = row_next;
               s_addr_in = row_next;
            end
         end else begin
            kc_in     = kc_ff + 3'd1;
            s_addr_in = s_addr_ff + SAMPLE_AW'(1);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Counters and addresses.
   always_ff @(posedge clock) begin
      kc_ff     <= kc_in;
      kr_ff     <= kr_in;
      ch_ff     <= ch_in;
      s_addr_ff <= s_addr_in;
      row_ff    <= row_in;
      chan_ff   <= chan_in;
      w_addr_ff <= w_addr_in;
   end

   assign issue.active = active_ff;
   assign issue.s_addr = s_addr_ff;
   assign issue.w_addr = w_addr_ff;

endmodule

/* rtl/core/c2d_mac.sv */
// Shared multiply-accumulate unit with bias preload and 32-bit saturation.
module c2d_mac import c2d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic signed [15:0] bias,
   input  logic               in_vld,
   input  logic signed [15:0] sample,
   input  logic signed [15:0] weight,
   output logic               busy,
   output logic signed [31:0] sat_result
);

   logic                    mul_vld_ff;
   logic signed [31:0]      prod_ff;
   logic signed [31:0]      prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    in_range;

   assign prod_in = sample * weight;

   // Bias enters as Q8.24; each product is registered and added in the cycle after it is formed.
   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = {{(ACC_W - 28){bias[15]}}, bias, 12'b0};
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= in_vld;
      end
   end

   // Product and accumulator.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // The sum fits when all bits above bit 30 agree.
   assign in_range = (acc_ff[ACC_W-1:31] == '0) || (acc_ff[ACC_W-1:31] == '1);

   always_comb begin
      if (in_range) begin
         sat_result = acc_ff[31:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_result = 32'sh8000_0000;
      end else begin
         sat_result = 32'sh7fff_ffff;
      end
   end

   assign busy = mul_vld_ff;

endmodule

/* rtl/core/c2d_checker.sv */
// Port-level checker for the convolution layer forward unit and its bind.
`include "assert_macros.svh"

module c2d_checker import c2d_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A result that is not taken stays posted with the same payload.
   `C2D_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A request outside the grid always reports a zero sum.
   `C2D_ASSERT_SAME(a_outside_zero, rsp_valid && rsp_data.status, rsp_data.result == '0)

   // A compute transfer occupies the unit in the following cycle.
   `C2D_ASSERT_NEXT(a_compute_busy, req_valid && req_ready && (req_data.kind == KIND_COMPUTE), !req_ready)

   // A load transfer leaves the unit free for the next request.
   `C2D_ASSERT_NEXT(a_load_free, req_valid && req_ready && (req_data.kind != KIND_COMPUTE), req_ready)

endmodule

bind conv2d_layer_forward_unit c2d_checker u_c2d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/tb.sv */
// Self-checking testbench for the convolution layer forward unit with directed and random traffic.
`timescale 1ns / 1ps

module tb;
   import c2d_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int IDLE_SETTLE = 12;
   localparam int MAX_IDLE    = 16;
   localparam int HOLD_CYCLES = 400;

   // Register indexes beyond the six defined ones; writes to them must change nothing.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   localparam logic signed [31:0] SUM_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SUM_MIN = 32'sh80000000;

   typedef struct {
      int unsigned w, h, c, nf, k, s, rows, cols;
   } geom_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [6:0] csr_data  = '0;

   // Predictor state: mirror of the stores and of the layer registers.
   logic signed [15:0] sample_mem [SAMPLE_DEPTH];
   logic signed [15:0] weight_mem [WEIGHT_DEPTH];
   logic signed [15:0] bias_mem   [BIAS_DEPTH];
   logic [6:0] lay_width    = 7'd1;
   logic [6:0] lay_height   = 7'd1;
   logic [4:0] lay_channels = 5'd1;
   logic [5:0] lay_filters  = 6'd1;
   logic [2:0] lay_kernel   = 3'd3;
   logic [2:0] lay_stride   = 3'd1;

   rsp_type conv_expect_q [$];
   rsp_type rsp_head;

   int send_idle_max = MAX_IDLE;
   int recv_idle_max = MAX_IDLE;
   int rsp_gap       = 0;
   int hold_off_req  = 0;
   int cycle_count   = 0;
   int err_count     = 0;
   int n_loads       = 0;
   int n_computes    = 0;
   int n_checked     = 0;
   int n_outside     = 0;
   int n_saturated   = 0;
   int n_settings    = 0;

   conv2d_layer_forward_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // A register value of zero acts as one and a value above the maximum acts as the maximum.
   function automatic int unsigned sat_reg(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Layer geometry as the block sees it, including the size of the output grid.
   function automatic geom_type layer_geom();
      geom_type g;
      g.w    = sat_reg(lay_width, MAX_WIDTH);
      g.h    = sat_reg(lay_height, MAX_HEIGHT);
      g.c    = sat_reg(lay_channels, MAX_CHANNELS);
      g.nf   = sat_reg(lay_filters, MAX_FILTERS);
      g.k    = sat_reg(lay_kernel, MAX_KERNEL);
      g.s    = sat_reg(lay_stride, MAX_STRIDE);
      g.rows = (g.h >= g.k) ? (g.h - g.k) / g.s + 1 : 0;
      g.cols = (g.w >= g.k) ? (g.w - g.k) / g.s + 1 : 0;
      return g;
   endfunction

   // Expected output of one compute request: windowed sum of products plus the scaled bias.
   function automatic rsp_type conv_output(input req_type r);
      geom_type    g;
      longint      acc;
      int unsigned ch, kr, kc, sa, wa;
      rsp_type     o;
      g = layer_geom();
      o.result = '0;
      o.status = STATUS_OUTSIDE;
      if (r.out_filter >= g.nf || r.out_row >= g.rows || r.out_col >= g.cols) return o;
      acc = longint'(bias_mem[r.out_filter]) * 4096;
      for (ch = 0; ch < g.c; ch++) begin
         for (kr = 0; kr < g.k; kr++) begin
            for (kc = 0; kc < g.k; kc++) begin
               sa = ch * g.h * g.w + (r.out_row * g.s + kr) * g.w + r.out_col * g.s + kc;
               wa = r.out_filter * g.k * g.k * g.c + ch * g.k * g.k + kr * g.k + kc;
               acc += longint'(sample_mem[sa]) * longint'(weight_mem[wa]);
            end
         end
      end
      if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
      if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
      o.result = acc[31:0];
      o.status = STATUS_OK;
      return o;
   endfunction

   // Load request; the compute fields carry noise.
   function automatic req_type make_load(input logic [1:0] kind, input int unsigned idx,
                                         input logic [15:0] val);
      req_type r;
      r.kind       = kind;
      r.index      = idx[15:0];
      r.value      = val;
      r.out_filter = 5'($urandom);
      r.out_row    = 6'($urandom);
      r.out_col    = 6'($urandom);
      return r;
   endfunction

   // Compute request; the load fields carry noise.
   function automatic req_type make_compute(input int unsigned f, input int unsigned row,
                                            input int unsigned col);
      req_type r;
      r.kind       = KIND_COMPUTE;
      r.index      = 16'($urandom);
      r.value      = 16'($urandom);
      r.out_filter = f[4:0];
      r.out_row    = row[5:0];
      r.out_col    = col[5:0];
      return r;
   endfunction

   // Sends one request after a random idle gap and updates the predictor on its transfer.
   task automatic send_req(input req_type item);
      int      gap;
      rsp_type exp_rsp;
      gap = $urandom_range(0, send_idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      case (item.kind)
         KIND_SAMPLE: begin
            if (item.index < SAMPLE_DEPTH) sample_mem[item.index] = item.value;
            n_loads++;
         end
         KIND_WEIGHT: begin
            if (item.index < WEIGHT_DEPTH) weight_mem[item.index] = item.value;
            n_loads++;
         end
         KIND_BIAS: begin
            if (item.index < BIAS_DEPTH) bias_mem[item.index] = item.value;
            n_loads++;
         end
         default: begin
            exp_rsp = conv_output(item);
            conv_expect_q.push_back(exp_rsp);
            n_computes++;
            if (exp_rsp.status == STATUS_OUTSIDE) n_outside++;
            else if (exp_rsp.result == SUM_MAX || exp_rsp.result == SUM_MIN) n_saturated++;
         end
      endcase
   endtask

   // Stops offering requests and waits until every expected result has been taken.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (conv_expect_q.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // One register write transfer on the configuration port.
   task automatic write_csr(input logic [2:0] idx, input logic [6:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIDTH:    lay_width    = data;
         CSR_HEIGHT:   lay_height   = data;
         CSR_CHANNELS: lay_channels = data[4:0];
         CSR_FILTERS:  lay_filters  = data[5:0];
         CSR_KERNEL:   lay_kernel   = data[2:0];
         CSR_STRIDE:   lay_stride   = data[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drains the block and programs all six layer registers.
   task automatic set_layer(input logic [6:0] w, input logic [6:0] h, input logic [6:0] c,
                            input logic [6:0] f, input logic [6:0] k, input logic [6:0] s);
      wait_idle();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_CHANNELS, c);
      write_csr(CSR_FILTERS, f);
      write_csr(CSR_KERNEL, k);
      write_csr(CSR_STRIDE, s);
      n_settings++;
   endtask

   // Writes every sample, weight and bias that the current geometry can read.
   task automatic fill_stores(input bit use_const, input logic signed [15:0] s_val,
                              input logic signed [15:0] w_val, input logic signed [15:0] b_val);
      geom_type    g;
      int          saved;
      int unsigned i;
      g = layer_geom();
      saved = send_idle_max;
      send_idle_max = 0;
      for (i = 0; i < g.c * g.h * g.w; i++)
         send_req(make_load(KIND_SAMPLE, i, use_const ? s_val : 16'($urandom)));
      for (i = 0; i < g.nf * g.k * g.k * g.c; i++)
         send_req(make_load(KIND_WEIGHT, i, use_const ? w_val : 16'($urandom)));
      for (i = 0; i < g.nf; i++)
         send_req(make_load(KIND_BIAS, i, use_const ? b_val : 16'($urandom)));
      send_idle_max = saved;
   endtask

   // Writes random weights and biases for every filter of the current geometry.
   task automatic fill_filters();
      geom_type    g;
      int          saved;
      int unsigned i;
      g = layer_geom();
      saved = send_idle_max;
      send_idle_max = 0;
      for (i = 0; i < g.nf * g.k * g.k * g.c; i++)
         send_req(make_load(KIND_WEIGHT, i, 16'($urandom)));
      for (i = 0; i < g.nf; i++)
         send_req(make_load(KIND_BIAS, i, 16'($urandom)));
      send_idle_max = saved;
   endtask

   // Writes random samples over the window of one output position in every channel.
   task automatic load_window(input int unsigned row, input int unsigned col);
      geom_type    g;
      int          saved;
      int unsigned ch, kr, kc;
      g = layer_geom();
      saved = send_idle_max;
      send_idle_max = 0;
      for (ch = 0; ch < g.c; ch++)
         for (kr = 0; kr < g.k; kr++)
            for (kc = 0; kc < g.k; kc++)
               send_req(make_load(KIND_SAMPLE, ch * g.h * g.w + (row * g.s + kr) * g.w +
                                  col * g.s + kc, 16'($urandom)));
      send_idle_max = saved;
   endtask

   // Compute request at a random point inside the grid; the caller checks the grid is not empty.
   task automatic send_in_grid();
      geom_type g;
      g = layer_geom();
      send_req(make_compute($urandom_range(0, g.nf - 1), $urandom_range(0, g.rows - 1),
                            $urandom_range(0, g.cols - 1)));
   endtask

   // Right after reset the kernel is larger than the 1x1 image, so every request is outside.
   task automatic test_reset_defaults();
      send_req(make_compute(0, 0, 0));
      send_req(make_load(KIND_SAMPLE, 65535, 16'sh7FFF));
      send_req(make_compute(31, 63, 63));
   endtask

   // Small layer: grid corners, each kind of out-of-grid request and ignored loads.
   task automatic test_small_grid();
      set_layer(7'd5, 7'd4, 7'd2, 7'd3, 7'd3, 7'd1);
      fill_stores(1'b0, '0, '0, '0);
      send_req(make_compute(0, 0, 0));
      send_req(make_compute(2, 1, 2));
      send_req(make_compute(1, 0, 2));
      send_req(make_compute(0, 1, 0));
      send_req(make_compute(3, 0, 0));
      send_req(make_compute(0, 2, 0));
      send_req(make_compute(0, 0, 3));
      send_req(make_compute(31, 63, 63));
      // Loads past the end of the weight and bias stores are dropped.
      send_req(make_load(KIND_BIAS, 32, 16'sh7FFF));
      send_req(make_load(KIND_BIAS, 65535, 16'sh8000));
      send_req(make_load(KIND_WEIGHT, WEIGHT_DEPTH, 16'sh7FFF));
      send_req(make_load(KIND_WEIGHT, 65535, 16'sh8000));
      send_req(make_compute(0, 0, 0));
      send_req(make_compute(2, 1, 2));
      // Extreme values at the first entries.
      send_req(make_load(KIND_SAMPLE, 0, 16'sh8000));
      send_req(make_load(KIND_WEIGHT, 0, 16'sh7FFF));
      send_req(make_load(KIND_BIAS, 0, 16'sh8000));
      send_req(make_compute(0, 0, 0));
   endtask

   // Nine full-scale products overflow the 32-bit result in both directions.
   task automatic test_saturation();
      set_layer(7'd3, 7'd3, 7'd1, 7'd1, 7'd3, 7'd1);
      fill_stores(1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF);
      send_req(make_compute(0, 0, 0));
      fill_stores(1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_req(make_compute(0, 0, 0));
   endtask

   // Zero and oversized register values, spare indexes, largest kernel and largest image.
   task automatic test_register_limits();
      set_layer(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      fill_stores(1'b0, '0, '0, '0);
      send_req(make_compute(0, 0, 0));
      send_req(make_compute(1, 0, 0));
      send_req(make_compute(0, 1, 0));
      wait_idle();
      write_csr(CSR_SPARE_LO, 7'h7F);
      write_csr(CSR_SPARE_HI, 7'h55);
      send_req(make_compute(0, 0, 0));
      send_req(make_compute(0, 0, 1));

      // Width and filter count clamp to their maxima; one-tap kernel with the largest stride.
      // Only the entries that the two in-grid requests read are loaded.
      set_layer(7'h7F, 7'd1, 7'd1, 7'h3F, 7'd1, 7'd7);
      send_req(make_load(KIND_SAMPLE, 63, 16'($urandom)));
      send_req(make_load(KIND_WEIGHT, 31, 16'($urandom)));
      send_req(make_load(KIND_BIAS, 31, 16'($urandom)));
      send_req(make_load(KIND_SAMPLE, 0, 16'($urandom)));
      send_req(make_load(KIND_WEIGHT, 0, 16'($urandom)));
      send_req(make_load(KIND_BIAS, 0, 16'($urandom)));
      send_req(make_compute(31, 0, 9));
      send_req(make_compute(31, 0, 10));
      send_req(make_compute(0, 0, 0));

      // Channel count clamps to its maximum: sixteen channels per output.
      set_layer(7'd1, 7'd1, 7'h1F, 7'd1, 7'd1, 7'd0);
      fill_stores(1'b0, '0, '0, '0);
      send_req(make_compute(0, 0, 0));
      send_req(make_compute(1, 0, 0));
      send_req(make_compute(0, 0, 1));

      // Largest image with the largest kernel; only the far corner window is loaded.
      set_layer(7'd64, 7'd64, 7'd1, 7'd1, 7'd7, 7'd7);
      fill_filters();
      load_window(8, 8);
      send_req(make_compute(0, 8, 8));
      send_req(make_compute(0, 9, 0));
      send_req(make_compute(0, 0, 9));

      // Kernel wider than the image leaves no output columns.
      set_layer(7'd3, 7'h7F, 7'd1, 7'd1, 7'd5, 7'd1);
      send_req(make_compute(0, 0, 0));
   endtask

   // The receiver holds off while requests keep coming, so the block stalls its input.
   task automatic test_backpressure();
      int saved_send, saved_recv;
      set_layer(7'd5, 7'd5, 7'd1, 7'd2, 7'd3, 7'd1);
      fill_stores(1'b0, '0, '0, '0);
      saved_send = send_idle_max;
      saved_recv = recv_idle_max;
      send_idle_max = 0;
      recv_idle_max = 0;
      @(posedge clock);
      hold_off_req = HOLD_CYCLES;
      repeat (24) send_in_grid();
      wait_idle();
      send_idle_max = saved_send;
      recv_idle_max = saved_recv;
   endtask

   // One random layer setting followed by a mix of loads and compute requests.
   task automatic run_random_phase(input int n_items);
      geom_type    g;
      int unsigned w, h, c, f, k, s, kmax, span;
      int          pick;
      logic [1:0]  kind;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      c = $urandom_range(1, 2);
      f = $urandom_range(1, 3);
      kmax = (w < h) ? w : h;
      if (kmax > 5) kmax = 5;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(1, kmax);
      s = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 7 : 3);
      // Now and then a register is written as zero, which acts as one.
      if ($urandom_range(0, 9) == 0) w = 0;
      if ($urandom_range(0, 9) == 0) h = 0;
      if ($urandom_range(0, 9) == 0) c = 0;
      if ($urandom_range(0, 9) == 0) f = 0;
      if ($urandom_range(0, 9) == 0) k = 0;
      if ($urandom_range(0, 9) == 0) s = 0;
      set_layer(w[6:0], h[6:0], c[6:0], f[6:0], k[6:0], s[6:0]);
      fill_stores(1'b0, '0, '0, '0);
      send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      g = layer_geom();
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && g.rows > 0 && g.cols > 0) begin
            send_in_grid();
         end else if (pick < 65) begin
            send_req(make_compute($urandom_range(0, 31), $urandom_range(0, 63),
                                  $urandom_range(0, 63)));
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  kind = KIND_SAMPLE;
                  span = g.c * g.h * g.w;
               end
               1: begin
                  kind = KIND_WEIGHT;
                  span = g.nf * g.k * g.k * g.c;
               end
               default: begin
                  kind = KIND_BIAS;
                  span = g.nf;
               end
            endcase
            // Mostly overwrite entries in use, sometimes anywhere in the index range.
            if ($urandom_range(0, 4) != 0)
               send_req(make_load(kind, $urandom_range(0, span - 1), 16'($urandom)));
            else
               send_req(make_load(kind, $urandom_range(0, 65535), 16'($urandom)));
         end
      end
   endtask

   task automatic test_random_traffic();
      repeat (3) run_random_phase(40);
      send_idle_max = MAX_IDLE;
      recv_idle_max = MAX_IDLE;
   endtask

   // Result receiver: a random stall after every transfer, and a long hold-off on request.
   initial begin : rsp_sink
      int n;
      forever begin
         @(negedge clock);
         if (hold_off_req != 0) begin
            n = hold_off_req;
            hold_off_req = 0;
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (rsp_gap != 0) begin
            rsp_gap = rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result checker: every transfer is compared with the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (conv_expect_q.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result: expected none, actual result %0d status %0d",
                     $time, $signed(rsp_data.result), rsp_data.status);
         end else begin
            rsp_head = conv_expect_q.pop_front();
            n_checked++;
            if (rsp_data.result !== rsp_head.result) begin
               err_count++;
               $display("%0t: result mismatch: expected %0d, actual %0d", $time,
                        $signed(rsp_head.result), $signed(rsp_data.result));
            end
            if (rsp_data.status !== rsp_head.status) begin
               err_count++;
               $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                        rsp_head.status, rsp_data.status);
            end
         end
         rsp_gap = $urandom_range(0, recv_idle_max);
      end
   end

   // Test sequence.
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_small_grid();
      test_saturation();
      test_register_limits();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (4 * IDLE_SETTLE) @(posedge clock);
      $display("Run covered %0d loads and %0d compute requests over %0d layer settings.",
               n_loads, n_computes, n_settings);
      $display("Checked %0d results: %0d outside the grid, %0d saturated, %0d errors.",
               n_checked, n_outside, n_saturated, err_count);
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
